// ----- sv/psw_pkg.sv -----
// Package with shared types and constants of the priority schedule wait times unit.
`default_nettype none

package psw_pkg;

  localparam int MAX_PROCS_DEF = 32;

  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int ID_W    = 6;
  localparam int TIME_W  = 21;
  localparam int TOTAL_W = 26;
  localparam int AVG_W   = 29;
  localparam int FRAC_W  = 8;
  localparam int DIVIDEND_W = TOTAL_W + FRAC_W;

  typedef struct packed {
    logic [BURST_W-1:0] burst_time;
    logic [PRIO_W-1:0]  prio_level;
    logic               last_item;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0]    process_id;
    logic [PRIO_W-1:0]  out_prio;
    logic [BURST_W-1:0] out_burst;
    logic [TIME_W-1:0]  wait_time;
    logic [TIME_W-1:0]  turnaround_time;
    logic [AVG_W-1:0]   avg_wait_fixed;
    logic [AVG_W-1:0]   avg_turnaround_fixed;
    logic               overflowed;
    logic               last_result;
  } out_word_t;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [ID_W-1:0]    id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ----- sv/psw_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module psw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/psw_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module psw_div #(
  parameter int DIVIDEND_W = 34,
  parameter int DIVISOR_W  = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic      [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W:0]    rem_r, rem_nxt;
  logic [DIVISOR_W:0]    shifted;
  logic                  fits;

  assign shifted  = {rem_r[DIVISOR_W-1:0], quo_r[DIVIDEND_W-1]};
  assign fits     = shifted >= {1'b0, divisor};
  assign done     = done_r;
  assign quotient = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIVIDEND_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? (shifted - {1'b0, divisor}) : shifted;
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

endmodule

`default_nettype wire

// ----- sv/priority_schedule_wait_times_unit.sv -----
// Top level of the priority schedule wait times unit: loader, exchange sorter and read-out.
// Each word that is not the last of a set is taken and written to the entry RAM, or dropped if it is full.
// The closing word starts the work on the n held entries: the exchange sort visits one entry
// per cycle through the single RAM read port, read-out reads each entry and then forms its
// result when the output is free, and the two averages share one divider at one bit per cycle.
// Synchronous active-low reset empties the set; RAM contents are not cleared.
`default_nettype none

module priority_schedule_wait_times_unit #(
  parameter int MAX_PROCS = psw_pkg::MAX_PROCS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire psw_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output psw_pkg::out_word_t      out_word
);

  import psw_pkg::*;

  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int ADDR_W = $clog2(MAX_PROCS);

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_SORT_I   = 4'd1;
  localparam logic [3:0] S_SORT_CUR = 4'd2;
  localparam logic [3:0] S_SCAN     = 4'd3;
  localparam logic [3:0] S_SORT_WB  = 4'd4;
  localparam logic [3:0] S_OUT_RD   = 4'd5;
  localparam logic [3:0] S_OUT_CALC = 4'd6;
  localparam logic [3:0] S_DIV_WS   = 4'd7;
  localparam logic [3:0] S_DIV_WW   = 4'd8;
  localparam logic [3:0] S_DIV_TS   = 4'd9;
  localparam logic [3:0] S_DIV_TW   = 4'd10;

  logic [3:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic               drop_r, drop_nxt;
  entry_t             cur_r, cur_nxt;
  logic [TIME_W-1:0]  run_r, run_nxt;
  logic [TOTAL_W-1:0] wtot_r, wtot_nxt;
  logic [TOTAL_W-1:0] ttot_r, ttot_nxt;
  out_word_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  entry_t                wr_data;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ENTRY_W-1:0]    rd_raw;
  entry_t                rd_entry;

  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quo;

  logic              in_accept;
  logic              is_full;
  logic [CNT_W-1:0]  n_val;
  entry_t            in_entry;
  logic [CNT_W-1:0]  i_plus1;
  logic [CNT_W-1:0]  j_plus1;
  logic [CNT_W:0]    i_plus2;
  logic              slot_free;
  logic [TIME_W-1:0] ta_time;

  assign in_stall  = (state_r != S_LOAD);
  assign in_accept = in_valid && !in_stall;
  assign is_full   = cnt_r >= CNT_W'(MAX_PROCS);
  assign n_val     = is_full ? cnt_r : (cnt_r + CNT_W'(1));
  assign in_entry  = '{prio: in_word.prio_level, burst: in_word.burst_time,
                       id: ID_W'(cnt_r) + ID_W'(1)};
  assign i_plus1   = i_r + CNT_W'(1);
  assign j_plus1   = j_r + CNT_W'(1);
  assign i_plus2   = {1'b0, i_r} + (CNT_W + 1)'(2);
  assign slot_free = !out_valid_r || !out_stall;
  assign rd_entry  = entry_t'(rd_raw);
  assign ta_time   = run_r + TIME_W'(rd_entry.burst);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  psw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PROCS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  psw_div #(
    .DIVIDEND_W (DIVIDEND_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (n_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    drop_nxt      = drop_r;
    cur_nxt       = cur_r;
    run_nxt       = run_r;
    wtot_nxt      = wtot_r;
    ttot_nxt      = ttot_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[ADDR_W-1:0];
    wr_data       = in_entry;
    rd_en         = 1'b0;
    rd_addr       = i_r[ADDR_W-1:0];
    div_start     = 1'b0;
    div_dividend  = {wtot_r, {FRAC_W{1'b0}}};

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_LOAD: begin
        if (in_accept) begin
          if (!is_full) begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_word.last_item) begin
            n_nxt    = n_val;
            cnt_nxt  = '0;
            i_nxt    = '0;
            run_nxt  = '0;
            wtot_nxt = '0;
            ttot_nxt = '0;
            state_nxt = (n_val >= CNT_W'(2)) ? S_SORT_I : S_OUT_RD;
          end
        end
      end
      S_SORT_I: begin
        rd_en     = 1'b1;
        state_nxt = S_SORT_CUR;
      end
      S_SORT_CUR: begin
        cur_nxt   = rd_entry;
        rd_en     = 1'b1;
        rd_addr   = i_plus1[ADDR_W-1:0];
        j_nxt     = i_plus1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (cur_r.prio < rd_entry.prio) begin
          wr_en   = 1'b1;
          wr_addr = j_r[ADDR_W-1:0];
          wr_data = cur_r;
          cur_nxt = rd_entry;
        end
        if (j_plus1 < n_r) begin
          rd_en   = 1'b1;
          rd_addr = j_plus1[ADDR_W-1:0];
          j_nxt   = j_plus1;
        end else begin
          state_nxt = S_SORT_WB;
        end
      end
      S_SORT_WB: begin
        wr_en   = 1'b1;
        wr_addr = i_r[ADDR_W-1:0];
        wr_data = cur_r;
        if (i_plus2 < {1'b0, n_r}) begin
          i_nxt     = i_plus1;
          rd_en     = 1'b1;
          rd_addr   = i_plus1[ADDR_W-1:0];
          state_nxt = S_SORT_CUR;
        end else begin
          i_nxt     = '0;
          state_nxt = S_OUT_RD;
        end
      end
      S_OUT_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_OUT_CALC;
      end
      S_OUT_CALC: begin
        if (slot_free) begin
          out_nxt.process_id           = rd_entry.id;
          out_nxt.out_prio             = rd_entry.prio;
          out_nxt.out_burst            = rd_entry.burst;
          out_nxt.wait_time            = run_r;
          out_nxt.turnaround_time      = ta_time;
          out_nxt.avg_wait_fixed       = '0;
          out_nxt.avg_turnaround_fixed = '0;
          out_nxt.overflowed           = drop_r;
          out_nxt.last_result          = (i_plus1 == n_r);
          run_nxt  = ta_time;
          wtot_nxt = wtot_r + TOTAL_W'(run_r);
          ttot_nxt = ttot_r + TOTAL_W'(ta_time);
          if (i_plus1 == n_r) begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_DIV_WS;
          end else begin
            out_valid_nxt = 1'b1;
            i_nxt         = i_plus1;
            state_nxt     = S_OUT_RD;
          end
        end
      end
      S_DIV_WS: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WW;
      end
      S_DIV_WW: begin
        if (div_done) begin
          out_nxt.avg_wait_fixed = div_quo[AVG_W-1:0];
          state_nxt              = S_DIV_TS;
        end
      end
      S_DIV_TS: begin
        div_start    = 1'b1;
        div_dividend = {ttot_r, {FRAC_W{1'b0}}};
        state_nxt    = S_DIV_TW;
      end
      S_DIV_TW: begin
        if (div_done) begin
          out_nxt.avg_turnaround_fixed = div_quo[AVG_W-1:0];
          out_valid_nxt = 1'b1;
          drop_nxt      = 1'b0;
          run_nxt       = '0;
          wtot_nxt      = '0;
          ttot_nxt      = '0;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      n_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      drop_r      <= 1'b0;
      run_r       <= '0;
      wtot_r      <= '0;
      ttot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      drop_r      <= drop_nxt;
      run_r       <= run_nxt;
      wtot_r      <= wtot_nxt;
      ttot_r      <= ttot_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  a_turnaround_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.turnaround_time == out_r.wait_time + TIME_W'(out_r.out_burst))
    else $error("turnaround differs from wait plus burst");

  a_avg_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.last_result) |->
      (out_r.avg_wait_fixed == '0 && out_r.avg_turnaround_fixed == '0))
    else $error("average reported on a word that is not the last");

  a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (i_r < j_r && j_r < n_r))
    else $error("sort scan index out of range");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PROCS))
    else $error("load count beyond capacity");

endmodule

`default_nettype wire

// ----- verif/psw_schedule_checker.sv -----
// Checker that predicts the priority schedule from accepted input words and compares result words.
`default_nettype none

module psw_schedule_checker #(
  parameter int MAX_PROCS = psw_pkg::MAX_PROCS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire psw_pkg::in_word_t  in_word,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire psw_pkg::out_word_t out_word,
  output int                      mismatch_count,
  output int                      awaited_count
);
  import psw_pkg::*;

  entry_t      held [MAX_PROCS];
  int unsigned held_count = 0;
  logic        dropped = 1'b0;
  out_word_t   schedule_q [$];
  int          mismatches = 0;

  task automatic load_word(input in_word_t w);
    entry_t             tmp;
    out_word_t          r;
    logic [TIME_W-1:0]  run_wait;
    logic [TOTAL_W-1:0] wait_sum;
    logic [TOTAL_W-1:0] ta_sum;
    int unsigned        n;
    if (held_count < MAX_PROCS) begin
      held[held_count].prio  = w.prio_level;
      held[held_count].burst = w.burst_time;
      held[held_count].id    = ID_W'(held_count + 1);
      held_count++;
    end else begin
      dropped = 1'b1;
    end
    if (!w.last_item) return;
    n = held_count;
    for (int i = 0; i + 1 < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (held[i].prio < held[j].prio) begin
          tmp = held[i];
          held[i] = held[j];
          held[j] = tmp;
        end
      end
    end
    run_wait = '0;
    wait_sum = '0;
    ta_sum = '0;
    for (int i = 0; i < n; i++) begin
      r = '0;
      r.process_id = held[i].id;
      r.out_prio = held[i].prio;
      r.out_burst = held[i].burst;
      r.wait_time = run_wait;
      r.turnaround_time = run_wait + TIME_W'(held[i].burst);
      wait_sum = wait_sum + TOTAL_W'(r.wait_time);
      ta_sum = ta_sum + TOTAL_W'(r.turnaround_time);
      r.overflowed = dropped;
      r.last_result = (i == n - 1);
      if (i == n - 1) begin
        r.avg_wait_fixed = AVG_W'((64'(wait_sum) << FRAC_W) / n);
        r.avg_turnaround_fixed = AVG_W'((64'(ta_sum) << FRAC_W) / n);
      end
      run_wait = r.turnaround_time;
      schedule_q.push_back(r);
    end
    held_count = 0;
    dropped = 1'b0;
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_word(input out_word_t want, input out_word_t got);
    check_field("process_id", want.process_id, got.process_id);
    check_field("out_prio", want.out_prio, got.out_prio);
    check_field("out_burst", want.out_burst, got.out_burst);
    check_field("wait_time", want.wait_time, got.wait_time);
    check_field("turnaround_time", want.turnaround_time, got.turnaround_time);
    check_field("avg_wait_fixed", want.avg_wait_fixed, got.avg_wait_fixed);
    check_field("avg_turnaround_fixed", want.avg_turnaround_fixed, got.avg_turnaround_fixed);
    check_field("overflowed", want.overflowed, got.overflowed);
    check_field("last_result", want.last_result, got.last_result);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_count = 0;
      dropped = 1'b0;
      schedule_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (schedule_q.size() == 0) begin
          $display("%0t: expected no result word, actual %h", $time, out_word);
          mismatches++;
        end else begin
          compare_word(schedule_q.pop_front(), out_word);
        end
      end
      if (in_valid && !in_stall) load_word(in_word);
    end
    mismatch_count <= mismatches;
    awaited_count <= schedule_q.size();
  end

endmodule

`default_nettype wire

// ----- verif/tb_priority_schedule_wait_times_unit.sv -----
// Testbench top for the priority schedule wait times unit: clock, reset, stimulus and verdict.
`default_nettype none

module tb_priority_schedule_wait_times_unit;
  import psw_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 800;
  localparam int SET_ITEMS    = 200;

  typedef enum int {STALL_NONE, STALL_SOME, STALL_HEAVY} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  in_word_t    in_word = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  out_word_t   out_word;
  int          mismatch_count;
  int          awaited_count;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  in_word_t    directed_words [$];
  int          sent;
  int          pick;

  always #10 clk = ~clk;

  priority_schedule_wait_times_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  psw_schedule_checker sched_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
      stall_left <= $urandom_range(8, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_SOME: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic put_word(input in_word_t w);
    int                         gap;
    logic [$bits(in_word_t)-1:0] noise;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        noise = $bits(in_word_t)'($urandom);
        in_valid <= 1'b0;
        in_word <= noise;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic run_set(input int size, input bit longest_bursts);
    in_word_t w;
    for (int k = 0; k < size; k++) begin
      if (longest_bursts) begin
        w.burst_time = 16'hFFFF;
      end else if ($urandom_range(0, 4) == 0) begin
        w.burst_time = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end else begin
        w.burst_time = 16'($urandom);
      end
      w.prio_level = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      w.last_item = (k == size - 1);
      put_word(w);
    end
  endtask

  initial begin
    directed_words = '{
      '{16'hFFFF, 8'd255, 1'b1},
      '{16'h0000, 8'd0,   1'b1},
      '{16'h0001, 8'd7,   1'b0}, '{16'h0002, 8'd7, 1'b0},
      '{16'h0003, 8'd7,   1'b0}, '{16'h0004, 8'd7, 1'b1},
      '{16'hFFFF, 8'd0,   1'b0}, '{16'hFFFF, 8'd1, 1'b0},
      '{16'h0000, 8'd128, 1'b0}, '{16'hFFFF, 8'd255, 1'b0},
      '{16'hAAAA, 8'd128, 1'b1},
      '{16'h5555, 8'd200, 1'b0}, '{16'h0064, 8'd100, 1'b0},
      '{16'h0001, 8'd0,   1'b1},
      '{16'd10, 8'd3, 1'b0}, '{16'd20, 8'd9, 1'b0}, '{16'd30, 8'd3, 1'b0},
      '{16'd40, 8'd9, 1'b0}, '{16'd50, 8'd0, 1'b0}, '{16'd60, 8'd3, 1'b1},
      '{16'h0000, 8'd255, 1'b0}, '{16'hFFFF, 8'd255, 1'b1}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_words[k]) put_word(directed_words[k]);

    run_set(MAX_PROCS_DEF, 1'b1);
    run_set(MAX_PROCS_DEF + 1, 1'b0);
    run_set(MAX_PROCS_DEF + 3, 1'b0);
    sent = 3 * MAX_PROCS_DEF;
    while (sent < SET_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) pick = $urandom_range(1, 4);
      else if (pick < 85) pick = $urandom_range(5, 12);
      else if (pick < 95) pick = $urandom_range(13, MAX_PROCS_DEF - 1);
      else pick = $urandom_range(MAX_PROCS_DEF, MAX_PROCS_DEF + 4);
      run_set(pick, 1'b0);
      sent += pick;
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (awaited_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
